FILE: hdl/text_line_to_message_header_framer_assert.svh
// Assertion macros for the header framer.
`ifndef TEXT_LINE_TO_MESSAGE_HEADER_FRAMER_ASSERT_SVH
`define TEXT_LINE_TO_MESSAGE_HEADER_FRAMER_ASSERT_SVH

`ifndef SYNTHESIS
`define TLMHF_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TLMHF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define TLMHF_ASSERT(lbl, clk, rstn, prop, msg)
`define TLMHF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: hdl/tlmhf_pkg.sv
`default_nettype none

package tlmhf_pkg;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_NL     = 8'h0A;

	localparam int ALIGN_BYTES = 8;
	localparam int ALIGN_W     = $clog2(ALIGN_BYTES);

	typedef enum logic [1:0] {
		SEC_PRE  = 2'd0,
		SEC_DESC = 2'd1,
		SEC_TOK  = 2'd2,
		SEC_PAD  = 2'd3
	} sec_t;

	typedef struct packed {
		logic ready;
		logic emit;
		sec_t sec;
		logic end_run;
		logic end_field;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic in_delim;
		logic skip;
		logic line_started;
		logic delim_q;
		logic slot_free;
		logic sec_last;
		logic len_zero;
		logic pad_zero;
	} st_t;

	function automatic logic is_delim(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_LPAREN) || (c == CH_NL);
	endfunction

	function automatic logic [7:0] field_code(input logic [1:0] idx);
		logic [7:0] r;
		unique case (idx)
			2'd0: r = 8'h36;
			2'd1: r = 8'h31;
			2'd2: r = 8'h32;
			default: r = 8'h33;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] field_type(input logic [1:0] idx);
		return (idx == 2'd1) ? 8'h6F : 8'h73;
	endfunction

	function automatic logic [7:0] pre_byte(input logic [3:0] idx, input logic [31:0] serial);
		logic [7:0] r;
		unique case (idx[3:2])
			2'd0: begin
				unique case (idx[1:0])
					2'd0: r = 8'h6C;
					2'd1: r = 8'h31;
					2'd2: r = 8'h30;
					default: r = 8'h31;
				endcase
			end
			2'd2: r = serial[8*idx[1:0] +: 8];
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/tlmhf_in_if.sv
`default_nettype none

interface tlmhf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink (input valid, input ch, output ready);
endinterface

`default_nettype wire

FILE: hdl/tlmhf_out_if.sv
`default_nettype none

interface tlmhf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;
	logic       header_done;
	logic       token_truncated;

	modport source (output valid, output out_byte, output last_of_run,
		output header_done, output token_truncated, input ready);
	modport sink (input valid, input out_byte, input last_of_run,
		input header_done, input token_truncated, output ready);
endinterface

`default_nettype wire

FILE: hdl/tlmhf_ram.sv
`default_nettype none

module tlmhf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 48
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: hdl/tlmhf_ctrl.sv
`default_nettype none
`include "text_line_to_message_header_framer_assert.svh"

module tlmhf_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire tlmhf_pkg::st_t st,
	output tlmhf_pkg::cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PRE  = 3'd1;
	localparam logic [2:0] ST_DESC = 3'd2;
	localparam logic [2:0] ST_TOK  = 3'd3;
	localparam logic [2:0] ST_PAD  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d       = state_q;
		cmd.ready     = 1'b0;
		cmd.emit      = 1'b0;
		cmd.sec       = tlmhf_pkg::SEC_PRE;
		cmd.end_run   = 1'b0;
		cmd.end_field = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (st.in_valid && !st.skip) begin
					if (!st.line_started) begin
						state_d = ST_PRE;
					end else if (st.in_delim) begin
						state_d = ST_DESC;
					end
				end
			end
			ST_PRE: begin
				cmd.sec  = tlmhf_pkg::SEC_PRE;
				cmd.emit = st.slot_free;
				if (st.slot_free && st.sec_last) begin
					if (st.delim_q) begin
						state_d = ST_DESC;
					end else begin
						cmd.end_run = 1'b1;
						state_d     = ST_IDLE;
					end
				end
			end
			ST_DESC: begin
				cmd.sec  = tlmhf_pkg::SEC_DESC;
				cmd.emit = st.slot_free;
				if (st.slot_free && st.sec_last) begin
					priority if (!st.len_zero) begin
						state_d = ST_TOK;
					end else if (!st.pad_zero) begin
						state_d = ST_PAD;
					end else begin
						cmd.end_run   = 1'b1;
						cmd.end_field = 1'b1;
						state_d       = ST_IDLE;
					end
				end
			end
			ST_TOK: begin
				cmd.sec  = tlmhf_pkg::SEC_TOK;
				cmd.emit = st.slot_free;
				if (st.slot_free && st.sec_last) begin
					if (!st.pad_zero) begin
						state_d = ST_PAD;
					end else begin
						cmd.end_run   = 1'b1;
						cmd.end_field = 1'b1;
						state_d       = ST_IDLE;
					end
				end
			end
			ST_PAD: begin
				cmd.sec  = tlmhf_pkg::SEC_PAD;
				cmd.emit = st.slot_free;
				if (st.slot_free && st.sec_last) begin
					cmd.end_run   = 1'b1;
					cmd.end_field = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`TLMHF_ASSERT(a_emit_needs_slot, clk, arst_n, cmd.emit |-> st.slot_free, "beat emitted into a full output register")
	`TLMHF_ASSERT_NEXT(a_pre_exit, clk, arst_n, state_q == ST_PRE && cmd.emit && st.sec_last, state_q == ST_DESC || state_q == ST_IDLE, "bad exit from preamble")
	`TLMHF_ASSERT(a_field_end_ends_run, clk, arst_n, cmd.end_field |-> cmd.end_run, "field end without run end")

endmodule

`default_nettype wire

FILE: hdl/tlmhf_dp.sv
`default_nettype none
`include "text_line_to_message_header_framer_assert.svh"

module tlmhf_dp #(
	parameter int MAX_TOKEN = 48
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             serial_we,
	input  wire logic [31:0]      serial_wdata,
	tlmhf_in_if.sink              text,
	tlmhf_out_if.source           hdr,
	input  wire tlmhf_pkg::cmd_t  cmd,
	output tlmhf_pkg::st_t        st
);

	localparam int CW = $clog2(MAX_TOKEN + 1);
	localparam int AW = $clog2(MAX_TOKEN);
	localparam int ALIGN_WL = tlmhf_pkg::ALIGN_W;

	logic [31:0]  serial_q;
	logic [2:0]   field_idx_q;
	logic         line_started_q;
	logic [CW-1:0] count_q;
	logic         ovf_q;
	logic         delim_q;
	logic         nl_q;
	logic [CW-1:0] byte_q;
	logic [CW-1:0] byte_d;
	logic         out_valid_q;
	logic [7:0]   out_byte_q;
	logic         out_last_q;
	logic         out_hd_q;
	logic         out_tr_q;

	logic         accept;
	logic         in_delim;
	logic         in_nl;
	logic         skip;
	logic         room;
	logic [ALIGN_WL-1:0] pad_len;
	logic         sec_last;
	logic [7:0]   gen_byte;
	logic [7:0]   rdata;

	assign accept   = text.valid && cmd.ready;
	assign in_delim = tlmhf_pkg::is_delim(text.ch);
	assign in_nl    = (text.ch == tlmhf_pkg::CH_NL);
	assign skip     = field_idx_q[2];
	assign room     = (count_q < CW'(MAX_TOKEN));
	assign pad_len  = ALIGN_WL'(ALIGN_WL'(0) - count_q[ALIGN_WL-1:0]);

	always_comb begin
		unique case (cmd.sec)
			tlmhf_pkg::SEC_PRE:  sec_last = (byte_q == CW'(15));
			tlmhf_pkg::SEC_DESC: sec_last = (byte_q == CW'(7));
			tlmhf_pkg::SEC_TOK:  sec_last = ((byte_q + CW'(1)) == count_q);
			default:             sec_last = ((byte_q + CW'(1)) == CW'(pad_len));
		endcase
	end

	always_comb begin
		unique case (cmd.sec)
			tlmhf_pkg::SEC_PRE: begin
				gen_byte = tlmhf_pkg::pre_byte(byte_q[3:0], serial_q);
			end
			tlmhf_pkg::SEC_DESC: begin
				unique case (byte_q[2:0])
					3'd0: gen_byte = tlmhf_pkg::field_code(field_idx_q[1:0]);
					3'd1: gen_byte = 8'h31;
					3'd2: gen_byte = tlmhf_pkg::field_type(field_idx_q[1:0]);
					3'd4: gen_byte = 8'(count_q);
					default: gen_byte = 8'h00;
				endcase
			end
			tlmhf_pkg::SEC_TOK: gen_byte = rdata;
			default:            gen_byte = 8'h00;
		endcase
	end

	always_comb begin
		byte_d = byte_q;
		if (cmd.emit) begin
			byte_d = sec_last ? '0 : byte_q + CW'(1);
		end
	end

	tlmhf_ram #(
		.WIDTH (8),
		.DEPTH (MAX_TOKEN)
	) u_store (
		.clk   (clk),
		.we    (accept && !skip && !in_delim && room),
		.waddr (count_q[AW-1:0]),
		.wdata (text.ch),
		.raddr (byte_d[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			serial_q       <= 32'd1;
			field_idx_q    <= '0;
			line_started_q <= 1'b0;
			count_q        <= '0;
			ovf_q          <= 1'b0;
			delim_q        <= 1'b0;
			nl_q           <= 1'b0;
			byte_q         <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			byte_q <= byte_d;
			if (serial_we) begin
				serial_q <= serial_wdata;
			end
			if (accept) begin
				if (skip) begin
					if (in_nl) begin
						field_idx_q    <= '0;
						line_started_q <= 1'b0;
						count_q        <= '0;
						ovf_q          <= 1'b0;
					end
				end else begin
					line_started_q <= 1'b1;
					delim_q        <= in_delim;
					nl_q           <= in_nl;
					if (!in_delim) begin
						if (room) begin
							count_q <= count_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
			end
			if (cmd.emit && cmd.end_field) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
				if (nl_q) begin
					field_idx_q    <= '0;
					line_started_q <= 1'b0;
				end else begin
					field_idx_q <= field_idx_q + 3'd1;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (hdr.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_byte_q <= gen_byte;
			out_last_q <= cmd.end_run;
			out_hd_q   <= cmd.end_field && (field_idx_q == 3'd3);
			out_tr_q   <= (cmd.sec != tlmhf_pkg::SEC_PRE) && ovf_q;
		end
	end

	assign text.ready          = cmd.ready;
	assign hdr.valid           = out_valid_q;
	assign hdr.out_byte        = out_byte_q;
	assign hdr.last_of_run     = out_last_q;
	assign hdr.header_done     = out_hd_q;
	assign hdr.token_truncated = out_tr_q;

	assign st.in_valid     = text.valid;
	assign st.in_delim     = in_delim;
	assign st.skip         = skip;
	assign st.line_started = line_started_q;
	assign st.delim_q      = delim_q;
	assign st.slot_free    = !out_valid_q || hdr.ready;
	assign st.sec_last     = sec_last;
	assign st.len_zero     = (count_q == '0);
	assign st.pad_zero     = (pad_len == '0);

	`TLMHF_ASSERT(a_done_is_last, clk, arst_n, (out_valid_q && out_hd_q) |-> out_last_q, "header done on a beat that does not end the run")
	`TLMHF_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(MAX_TOKEN), "token count above buffer size")
	`TLMHF_ASSERT(a_field_idx_bound, clk, arst_n, field_idx_q <= 3'd4, "field index past fourth field")

endmodule

`default_nettype wire

FILE: hdl/text_line_to_message_header_framer.sv
// Text line to message header framer.
// text: one character per beat (valid/ready, payload ch). hdr: one header
// byte per beat with last_of_run, header_done and token_truncated flags.
// serial_we/serial_wdata load the 32-bit serial; write it only while idle.
// The first character of a line produces a 16-byte preamble. Ordinary
// characters are buffered in a MAX_TOKEN-deep RAM, one per cycle, and
// produce nothing more. A space, '(' or newline produces an 8-byte field
// descriptor, the token bytes and zero padding to an 8-byte boundary.
// After the fourth field characters are dropped until a newline.
// A character that starts a run is registered into the sequencer state, which
// then loads the bytes of the run into the single output register, one per
// cycle while the receiver is ready (16 preamble bytes, 8 + len + pad per
// field). text.ready is low while a run is being sent. A stalled receiver
// freezes the sequencer; nothing is lost.
// Reset clears line state, the serial returns to 1 and hdr goes idle.
`default_nettype none

module text_line_to_message_header_framer #(
	parameter int MAX_TOKEN = 48
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        serial_we,
	input  wire logic [31:0] serial_wdata,
	tlmhf_in_if.sink         text,
	tlmhf_out_if.source      hdr
);

	tlmhf_pkg::cmd_t cmd;
	tlmhf_pkg::st_t  st;

	tlmhf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	tlmhf_dp #(
		.MAX_TOKEN (MAX_TOKEN)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.serial_we    (serial_we),
		.serial_wdata (serial_wdata),
		.text         (text),
		.hdr          (hdr),
		.cmd          (cmd),
		.st           (st)
	);

endmodule

`default_nettype wire

FILE: dv/text_line_to_message_header_framer_tb.sv
`timescale 1ns / 100ps

module text_line_to_message_header_framer_tb;

	localparam int TOKEN_MAX   = 48;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE      = 24;
	localparam int WATCHDOG    = 4000;
	localparam int RAND_ITEMS  = 170;
	localparam int PHASES      = 5;

	localparam logic [7:0] FIELD_CODE [4] = '{"6", "1", "2", "3"};
	localparam logic [7:0] FIELD_TYPE [4] = '{"s", "o", "s", "s"};
	localparam logic [7:0] MAGIC      [4] = '{"l", "1", "0", "1"};

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       done;
		logic       trunc;
	} hdr_beat_t;

	logic clk;
	logic arst_n;
	logic serial_we;
	logic [31:0] serial_wdata;

	tlmhf_in_if  text_if();
	tlmhf_out_if hdr_if();

	text_line_to_message_header_framer #(
		.MAX_TOKEN(TOKEN_MAX)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.serial_we(serial_we),
		.serial_wdata(serial_wdata),
		.text(text_if),
		.hdr(hdr_if)
	);

	logic [7:0] char_pending [$];
	hdr_beat_t  hdr_expected [$];

	// framing state mirror
	logic [31:0] line_serial = 32'd1;
	logic [2:0]  fld_idx     = '0;
	logic        line_open   = 1'b0;
	logic        skip_rest   = 1'b0;
	logic [7:0]  tok_buf [TOKEN_MAX];
	logic [5:0]  tok_len     = '0;
	logic        tok_cut     = 1'b0;

	int  mismatches   = 0;
	int  src_idle_pct = 0;
	int  rx_stall_pct = 0;
	int  quiet_cycles = 0;
	int  hold_left    = 0;
	bit  hold_req     = 0;
	bit  hold_used    = 0;
	logic text_beat   = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic is_sep(input logic [7:0] c);
		return c == tlmhf_pkg::CH_SPACE || c == tlmhf_pkg::CH_LPAREN || c == tlmhf_pkg::CH_NL;
	endfunction

	function automatic void clear_line();
		fld_idx   = '0;
		line_open = 1'b0;
		skip_rest = 1'b0;
		tok_len   = '0;
		tok_cut   = 1'b0;
	endfunction

	function automatic void frame_char(input logic [7:0] c);
		hdr_beat_t run [$];
		int pad;
		logic [31:0] len32;
		if (skip_rest || fld_idx >= 4) begin
			if (c == tlmhf_pkg::CH_NL)
				clear_line();
			return;
		end
		if (!line_open) begin
			for (int i = 0; i < 4; i++) run.push_back('{MAGIC[i], 1'b0, 1'b0, 1'b0});
			for (int i = 0; i < 4; i++) run.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
			for (int i = 0; i < 4; i++)
				run.push_back('{line_serial[8*i +: 8], 1'b0, 1'b0, 1'b0});
			for (int i = 0; i < 4; i++) run.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
			line_open = 1'b1;
		end
		if (is_sep(c)) begin
			len32 = 32'(tok_len);
			pad = (tlmhf_pkg::ALIGN_BYTES - (int'(tok_len) % tlmhf_pkg::ALIGN_BYTES))
				% tlmhf_pkg::ALIGN_BYTES;
			run.push_back('{FIELD_CODE[fld_idx[1:0]], 1'b0, 1'b0, tok_cut});
			run.push_back('{8'h31, 1'b0, 1'b0, tok_cut});
			run.push_back('{FIELD_TYPE[fld_idx[1:0]], 1'b0, 1'b0, tok_cut});
			run.push_back('{8'h00, 1'b0, 1'b0, tok_cut});
			for (int i = 0; i < 4; i++) run.push_back('{len32[8*i +: 8], 1'b0, 1'b0, tok_cut});
			for (int i = 0; i < tok_len; i++) run.push_back('{tok_buf[i], 1'b0, 1'b0, tok_cut});
			for (int i = 0; i < pad; i++) run.push_back('{8'h00, 1'b0, 1'b0, tok_cut});
			if (fld_idx == 3)
				run[run.size()-1].done = 1'b1;
			tok_len = '0;
			tok_cut = 1'b0;
			fld_idx = fld_idx + 1;
			if (c == tlmhf_pkg::CH_NL)
				clear_line();
			else if (fld_idx >= 4)
				skip_rest = 1'b1;
		end else if (tok_len < TOKEN_MAX) begin
			tok_buf[tok_len] = c;
			tok_len = tok_len + 1;
		end else begin
			tok_cut = 1'b1;
		end
		if (run.size() > 0) begin
			run[run.size()-1].last = 1'b1;
			foreach (run[i]) hdr_expected.push_back(run[i]);
		end
	endfunction

	function automatic logic [7:0] token_char();
		logic [7:0] c;
		do begin
			if ($urandom_range(99) < 70)
				c = 8'($urandom_range(33, 126));
			else
				c = 8'($urandom_range(255));
		end while (is_sep(c));
		return c;
	endfunction

	// queues one line of input, returns the number of characters queued
	function automatic int queue_line();
		int n0, ntok, len, r;
		n0 = char_pending.size();
		r = $urandom_range(99);
		if (r < 8) begin
			repeat ($urandom_range(1, 10)) char_pending.push_back(8'($urandom_range(255)));
			return char_pending.size() - n0;
		end
		ntok = (r < 22) ? $urandom_range(1, 3) : 4;
		for (int t = 0; t < ntok; t++) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(40, 56) : $urandom_range(0, 6);
			for (int i = 0; i < len; i++) char_pending.push_back(token_char());
			if (t == ntok - 1 && (ntok < 4 || $urandom_range(1)))
				char_pending.push_back(tlmhf_pkg::CH_NL);
			else
				char_pending.push_back($urandom_range(1) ? tlmhf_pkg::CH_SPACE
					: tlmhf_pkg::CH_LPAREN);
		end
		if (char_pending[$] != tlmhf_pkg::CH_NL) begin
			repeat ($urandom_range(0, 5)) char_pending.push_back(token_char());
			char_pending.push_back(tlmhf_pkg::CH_NL);
		end
		return char_pending.size() - n0;
	endfunction

	task automatic note_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic wait_drain();
		while (char_pending.size() != 0 || text_if.valid || hdr_expected.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic load_serial(input logic [31:0] v);
		@(negedge clk);
		serial_we    <= 1'b1;
		serial_wdata <= v;
		line_serial   = v;
		@(negedge clk);
		serial_we <= 1'b0;
	endtask

	// text side driver
	always @(negedge clk) begin : text_drive
		logic offer;
		if (!arst_n) begin
			text_if.valid <= 1'b0;
			text_if.ch    <= '0;
		end else if (!text_if.valid || text_beat) begin
			offer = char_pending.size() > 0 && $urandom_range(99) >= src_idle_pct;
			if (offer) begin
				text_if.ch    <= char_pending.pop_front();
				text_if.valid <= 1'b1;
			end else begin
				text_if.valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, counted in cycles
	always @(negedge clk) begin : hold_count
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_used) begin
			hold_used <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end
	end

	// header side ready
	always @(negedge clk) begin : hdr_ready
		if (!arst_n) begin
			hdr_if.ready <= 1'b0;
		end else if (hold_left > 0 || (hold_req && !hold_used)) begin
			hdr_if.ready <= 1'b0;
		end else begin
			hdr_if.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		text_beat <= arst_n && text_if.valid && text_if.ready;
		if (arst_n && text_if.valid && text_if.ready)
			frame_char(text_if.ch);
	end

	always @(posedge clk) begin : hdr_check
		hdr_beat_t want;
		if (arst_n && hdr_if.valid && hdr_if.ready) begin
			if (hdr_expected.size() == 0) begin
				note_mismatch($sformatf("unexpected beat, byte %02h", hdr_if.out_byte));
			end else begin
				want = hdr_expected.pop_front();
				if (hdr_if.out_byte !== want.data)
					note_mismatch($sformatf("out_byte %02h, want %02h",
						hdr_if.out_byte, want.data));
				if (hdr_if.last_of_run !== want.last)
					note_mismatch($sformatf("last_of_run %b, want %b (byte %02h)",
						hdr_if.last_of_run, want.last, want.data));
				if (hdr_if.header_done !== want.done)
					note_mismatch($sformatf("header_done %b, want %b (byte %02h)",
						hdr_if.header_done, want.done, want.data));
				if (hdr_if.token_truncated !== want.trunc)
					note_mismatch($sformatf("token_truncated %b, want %b (byte %02h)",
						hdr_if.token_truncated, want.trunc, want.data));
			end
		end
	end

	always @(posedge clk) begin
		if ((text_if.valid && text_if.ready) || (hdr_if.valid && hdr_if.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		int sent;
		logic [7:0] dir [$];
		arst_n        = 1'b0;
		serial_we     = 1'b0;
		serial_wdata  = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty line, byte extremes, empty field, skip after the
		// fourth field, short line, newline closing the fourth field
		dir = '{tlmhf_pkg::CH_NL,
			8'h00, 8'hFF, tlmhf_pkg::CH_SPACE, tlmhf_pkg::CH_LPAREN, "q",
			tlmhf_pkg::CH_SPACE, "m", tlmhf_pkg::CH_SPACE, "k", "(", tlmhf_pkg::CH_NL,
			"w", tlmhf_pkg::CH_NL,
			"a", tlmhf_pkg::CH_SPACE, "b", tlmhf_pkg::CH_LPAREN, "c",
			tlmhf_pkg::CH_SPACE, "d", tlmhf_pkg::CH_NL};
		foreach (dir[i]) char_pending.push_back(dir[i]);
		sent = dir.size();
		wait_drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: load_serial(32'h0000_0000);
				1: load_serial(32'hFFFF_FFFF);
				2: load_serial($urandom);
				3: load_serial(32'h8000_0001);
				default: load_serial($urandom);
			endcase
			src_idle_pct = (ph == 1) ? 78 : (ph == 3) ? 8 : 0;
			rx_stall_pct = (ph == 2) ? 78 : (ph == 3) ? 8 : 0;
			do
				sent += queue_line();
			while (sent < (RAND_ITEMS * (ph + 1)) / PHASES);
			if (ph == PHASES - 1)
				hold_req = 1;
			wait_drain();
		end

		if (hdr_expected.size() != 0)
			note_mismatch($sformatf("%0d expected beats never arrived", hdr_expected.size()));
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
